/* hw/rtl/wpbe_pkg.sv */
// Shared types and constants for the WS2812 pixel bit encoder.
// No dependencies; every other file of the block but wpbe_if imports this package.
package wpbe_pkg;

    // Slot and counter geometry
    localparam int SLOTS_PER_PIXEL    = 24;
    localparam int SLOT_CNT_W         = 7;
    localparam int PIXEL_CNT_W        = 9;
    localparam int MAX_PIXELS_DEFAULT = 256;
    localparam logic [SLOT_CNT_W-1:0] RESET_SLOTS_MAX = 7'd64;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 3'd4;

    // Register reset values
    localparam logic [7:0]            DUTY_ZERO_RST   = 8'd19;
    localparam logic [7:0]            DUTY_ONE_RST    = 8'd38;
    localparam logic [7:0]            GREEN_SCALE_RST = 8'hB0;
    localparam logic [7:0]            BLUE_SCALE_RST  = 8'hF0;
    localparam logic [SLOT_CNT_W-1:0] RESET_SLOTS_RST = 7'd48;

    // Current register contents
    typedef struct packed {
        logic [7:0]            duty_zero;
        logic [7:0]            duty_one;
        logic [7:0]            green_scale;
        logic [7:0]            blue_scale;
        logic [SLOT_CNT_W-1:0] reset_slots;
    } cfg_t;

    // One prepared word handed from the color stage to the serializer
    typedef struct packed {
        logic                       eof;
        logic [SLOTS_PER_PIXEL-1:0] bits;
        logic [SLOT_CNT_W-1:0]      slots;
    } word_t;

endpackage

/* hw/rtl/wpbe_if.sv */
// Valid/ready channel interfaces for the WS2812 pixel bit encoder.
// Pixel input channel and slot output channel; no package dependencies.
interface wpbe_pixel_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, command, red, green, blue, input ready);
    modport sink   (input valid, command, red, green, blue, output ready);
endinterface

interface wpbe_slot_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       last;

    modport source (output valid, duty, last, input ready);
    modport sink   (input valid, duty, last, output ready);
endinterface

/* hw/rtl/ws2812_pixel_bit_encoder.sv */
// Top level of the WS2812 pixel bit encoder.
// Depends on wpbe_pkg, wpbe_if, wpbe_cfg_regs, wpbe_color, wpbe_serializer.
//
// Usage:
//   pixel (sink): one word per pixel (command 0, red/green/blue) or an
//     end-of-frame marker (command 1, colors ignored).
//   slot (source): one PWM compare value per word on the line. A pixel gives
//     24 slots, G then R then B, MSB first; an end-of-frame gives
//     min(reset_slots, 64) zero slots. last marks the final slot of an input.
//   cfg_we/cfg_index/cfg_data: register writes, taken at once; write only
//     while the block is idle.
// Path: an input word passes the color stage register, the serializer shift register and the slot output register.
// Throughput: one slot per cycle while the receiver is ready, set by the shift
//   register in the serializer; the color stage holds one further word.
// Pixels beyond MAX_PIXELS in a frame are dropped silently; an end-of-frame
//   with zero reset slots produces nothing but still restarts the count.
// Reset: registers return to defaults, pixel count clears, both stages empty.
// A stalled receiver holds the current slot; the serializer pauses and the
//   input stalls once the color stage holds a pending word.
module ws2812_pixel_bit_encoder
    import wpbe_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    wpbe_pixel_if.sink            pixel,
    wpbe_slot_if.source           slot,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    logic  word_valid;
    logic  word_ready;
    word_t word;

    // Register file
    wpbe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Color correction and frame limit
    wpbe_color #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_color (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word)
    );

    // Slot generation
    wpbe_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word),
        .cfg        (cfg),
        .slot       (slot)
    );

endmodule

/* hw/rtl/wpbe_cfg_regs.sv */
// Configuration register file of the WS2812 pixel bit encoder.
// Depends on wpbe_pkg for register indexes, reset values and cfg_t.
module wpbe_cfg_regs
    import wpbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DUTY_ZERO:   cfg_next.duty_zero   = cfg_data;
                REG_DUTY_ONE:    cfg_next.duty_one    = cfg_data;
                REG_GREEN_SCALE: cfg_next.green_scale = cfg_data;
                REG_BLUE_SCALE:  cfg_next.blue_scale  = cfg_data;
                REG_RESET_SLOTS: cfg_next.reset_slots = cfg_data[SLOT_CNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_zero   <= DUTY_ZERO_RST;
            cfg_reg.duty_one    <= DUTY_ONE_RST;
            cfg_reg.green_scale <= GREEN_SCALE_RST;
            cfg_reg.blue_scale  <= BLUE_SCALE_RST;
            cfg_reg.reset_slots <= RESET_SLOTS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/wpbe_color.sv */
// Input stage: color correction, frame pixel limit and word preparation.
// Depends on wpbe_pkg (cfg_t, word_t) and the wpbe_pixel_if interface.
module wpbe_color
    import wpbe_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    wpbe_pixel_if.sink        pixel,
    input  cfg_t              cfg,
    output logic              word_valid,
    input  logic              word_ready,
    output word_t             word
);

    localparam logic [PIXEL_CNT_W-1:0] MAX_CNT = PIXEL_CNT_W'(MAX_PIXELS);

    logic                   word_valid_reg;
    logic                   word_valid_next;
    word_t                  word_reg;
    word_t                  word_next;
    logic [PIXEL_CNT_W-1:0] pixel_count_reg;
    logic [PIXEL_CNT_W-1:0] pixel_count_next;

    logic                   accept;
    logic [15:0]            green_prod;
    logic [15:0]            blue_prod;
    logic [SLOT_CNT_W-1:0]  eof_slots;

    assign pixel.ready = !word_valid_reg || word_ready;
    assign accept      = pixel.valid && pixel.ready;

    // Scale green and blue, keep the top byte of each product
    assign green_prod = 16'(pixel.green) * 16'(cfg.green_scale);
    assign blue_prod  = 16'(pixel.blue) * 16'(cfg.blue_scale);

    // Clamp the latch reset length
    assign eof_slots = (cfg.reset_slots > RESET_SLOTS_MAX) ? RESET_SLOTS_MAX
                                                           : cfg.reset_slots;

    // Build the next word; drop items that produce no slot
    always_comb
    begin
        word_next        = word_reg;
        pixel_count_next = pixel_count_reg;
        word_valid_next  = word_valid_reg && !word_ready;
        if (accept)
        begin
            if (pixel.command)
            begin
                word_next.eof    = 1'b1;
                word_next.bits   = '0;
                word_next.slots  = eof_slots;
                word_valid_next  = (eof_slots != '0);
                pixel_count_next = '0;
            end
            else if (pixel_count_reg < MAX_CNT)
            begin
                word_next.eof    = 1'b0;
                word_next.bits   = {green_prod[15:8], pixel.red, blue_prod[15:8]};
                word_next.slots  = SLOT_CNT_W'(SLOTS_PER_PIXEL);
                word_valid_next  = 1'b1;
                pixel_count_next = pixel_count_reg + 1'b1;
            end
            else
            begin
                word_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg  <= 1'b0;
            pixel_count_reg <= '0;
        end
        else
        begin
            word_valid_reg  <= word_valid_next;
            pixel_count_reg <= pixel_count_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;

`ifndef SYNTHESIS
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_count_reg <= MAX_CNT)
        else $error("pixel count above frame limit");

    a_word_slots: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid_reg |-> (word_reg.slots != '0) && (word_reg.slots <= RESET_SLOTS_MAX))
        else $error("pending word with bad slot count");
`endif

endmodule

/* hw/rtl/wpbe_serializer.sv */
// Bit serializer: one PWM compare slot per cycle into an output register while the receiver is ready.
// Depends on wpbe_pkg (cfg_t, word_t) and the wpbe_slot_if interface.
module wpbe_serializer
    import wpbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    output logic        word_ready,
    input  word_t       word,
    input  cfg_t        cfg,
    wpbe_slot_if.source slot
);

    logic                       busy_reg;
    logic                       busy_next;
    logic                       eof_reg;
    logic                       eof_next;
    logic [SLOTS_PER_PIXEL-1:0] shift_reg;
    logic [SLOTS_PER_PIXEL-1:0] shift_next;
    logic [SLOT_CNT_W-1:0]      remaining_reg;
    logic [SLOT_CNT_W-1:0]      remaining_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [7:0]                 duty_reg;
    logic [7:0]                 duty_next;
    logic                       last_reg;
    logic                       last_next;

    logic                       advance;
    logic                       final_slot;
    logic                       load;

    // Advance when a slot is pending and the output register frees up
    assign advance    = busy_reg && (!out_valid_reg || slot.ready);
    assign final_slot = (remaining_reg == SLOT_CNT_W'(1));
    assign word_ready = !busy_reg || (advance && final_slot);
    assign load       = word_valid && word_ready;

    always_comb
    begin
        busy_next      = busy_reg;
        eof_next       = eof_reg;
        shift_next     = shift_reg;
        remaining_next = remaining_reg;
        out_valid_next = out_valid_reg && !slot.ready;
        duty_next      = duty_reg;
        last_next      = last_reg;

        // Emit the current bit, MSB first
        if (advance)
        begin
            out_valid_next = 1'b1;
            duty_next      = eof_reg ? 8'd0
                                     : (shift_reg[SLOTS_PER_PIXEL-1] ? cfg.duty_one
                                                                     : cfg.duty_zero);
            last_next      = final_slot;
            shift_next     = {shift_reg[SLOTS_PER_PIXEL-2:0], 1'b0};
            remaining_next = remaining_reg - 1'b1;
            busy_next      = !final_slot;
        end

        // Take the next word
        if (load)
        begin
            busy_next      = 1'b1;
            eof_next       = word.eof;
            shift_next     = word.bits;
            remaining_next = word.slots;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        eof_reg       <= eof_next;
        shift_reg     <= shift_next;
        remaining_reg <= remaining_next;
        duty_reg      <= duty_next;
        last_reg      <= last_next;
    end

    assign slot.valid = out_valid_reg;
    assign slot.duty  = duty_reg;
    assign slot.last  = last_reg;

`ifndef SYNTHESIS
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (remaining_reg != '0))
        else $error("serializer busy with no slots left");

    a_pixel_len: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !eof_reg) |-> (remaining_reg <= SLOT_CNT_W'(SLOTS_PER_PIXEL)))
        else $error("pixel word longer than one pixel");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && final_slot && !load) |=> !busy_reg && slot.last)
        else $error("final slot did not end the word");
`endif

endmodule

/* dv/wpbe_tb_pkg.sv */
`timescale 1ns / 1ps
// Slot scoreboard for the WS2812 pixel bit encoder testbench: mirrors the
// registers and pixel count, predicts the slot words of each input word.
// Depends on wpbe_pkg.
package wpbe_tb_pkg;
    import wpbe_pkg::*;

    localparam logic CMD_PIXEL  = 1'b0;
    localparam logic CMD_EOF    = 1'b1;
    localparam int   REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] duty;
        logic       last;
    } slot_word_t;

    class slot_scoreboard;
        cfg_t                   regs;
        logic [PIXEL_CNT_W-1:0] pixel_count;
        slot_word_t             expected_slots[$];
        int                     mismatches;
        int                     slots_seen;

        function new();
            regs.duty_zero   = DUTY_ZERO_RST;
            regs.duty_one    = DUTY_ONE_RST;
            regs.green_scale = GREEN_SCALE_RST;
            regs.blue_scale  = BLUE_SCALE_RST;
            regs.reset_slots = RESET_SLOTS_RST;
            pixel_count      = '0;
            mismatches       = 0;
            slots_seen       = 0;
        endfunction

        // Mirror one register write; unknown indexes are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DUTY_ZERO:   regs.duty_zero   = data;
                REG_DUTY_ONE:    regs.duty_one    = data;
                REG_GREEN_SCALE: regs.green_scale = data;
                REG_BLUE_SCALE:  regs.blue_scale  = data;
                REG_RESET_SLOTS: regs.reset_slots = data[SLOT_CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Keep the top byte of the 16-bit product
        function logic [7:0] scaled(logic [7:0] value, logic [7:0] factor);
            logic [15:0] prod;
            prod = 16'(value) * 16'(factor);
            return prod[15:8];
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction

        // Predict the slots of one accepted input word
        function void note_word(logic cmd, logic [7:0] red, logic [7:0] green,
                                logic [7:0] blue);
            logic [SLOTS_PER_PIXEL-1:0] bits;
            slot_word_t                 s;
            int                         n;
            int                         k;
            if (cmd == CMD_EOF) begin
                // latch reset: zero slots, count clamped, frame restarts
                n = regs.reset_slots;
                if (n > RESET_SLOTS_MAX)
                    n = RESET_SLOTS_MAX;
                for (k = 0; k < n; k++) begin
                    s.duty = 8'd0;
                    s.last = (k == n - 1);
                    expected_slots.push_back(s);
                end
                pixel_count = '0;
            end
            else if (pixel_count >= MAX_PIXELS_DEFAULT) begin
                // frame full: pixel dropped
                pixel_count = PIXEL_CNT_W'(MAX_PIXELS_DEFAULT);
            end
            else begin
                bits = {scaled(green, regs.green_scale), red,
                        scaled(blue, regs.blue_scale)};
                for (k = SLOTS_PER_PIXEL - 1; k >= 0; k--) begin
                    s.duty = bits[k] ? regs.duty_one : regs.duty_zero;
                    s.last = (k == 0);
                    expected_slots.push_back(s);
                end
                pixel_count = pixel_count + 1'b1;
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("MISMATCH: %s", msg);
        endfunction

        // Compare one accepted slot word against the oldest prediction
        function void check_slot(logic [7:0] duty, logic last);
            slot_word_t want;
            slots_seen++;
            if (expected_slots.size() == 0) begin
                report($sformatf("slot %0d unexpected: duty %0d last %0b",
                                 slots_seen, duty, last));
                return;
            end
            want = expected_slots.pop_front();
            if (want.duty !== duty)
                report($sformatf("slot %0d duty: expected %0d, actual %0d",
                                 slots_seen, want.duty, duty));
            if (want.last !== last)
                report($sformatf("slot %0d last: expected %0b, actual %0b",
                                 slots_seen, want.last, last));
        endfunction
    endclass

endpackage

/* dv/ws2812_pixel_bit_encoder_tb.sv */
`timescale 1ns / 1ps
// Top of the WS2812 pixel bit encoder testbench: clock, reset, pixel driver,
// slot receiver with random stalls and a long hold-off, watchdog.
// Depends on wpbe_pkg, wpbe_if, wpbe_tb_pkg and the encoder RTL.
module ws2812_pixel_bit_encoder_tb;
    import wpbe_pkg::*;
    import wpbe_tb_pkg::*;

    // Cycles to let a word with no slots drain before a register write
    localparam int SETTLE_CYCLES   = 8;
    // Longest legal quiet stretch is the hold-off plus a settle; allow far more
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 200;
    localparam int HOLD_EVERY      = 1500;
    localparam int RANDOM_PHASES   = 9;
    localparam int LONG_PHASE      = 4;
    localparam int WORDS_PER_PHASE = 24;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    idle_on;
    int                    stall_cycles;
    int                    slots_taken;
    int                    next_hold;
    slot_scoreboard        sb;

    wpbe_pixel_if pixel_ch ();
    wpbe_slot_if  slot_ch ();

    ws2812_pixel_bit_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .slot      (slot_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Mostly random bytes, with the two extremes drawn often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Reset length: mostly short, sometimes zero, the maximum or beyond it
    function automatic logic [7:0] pick_slots();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd64;
            2:       return 8'($urandom_range(65, 255));
            3:       return 8'd1;
            default: return 8'($urandom_range(2, 16));
        endcase
    endfunction

    // Drop valid and wait until every predicted slot is out and the block drains
    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all registers, then one index past the map
    task automatic load_regs(input logic [7:0] dz, input logic [7:0] d1,
                             input logic [7:0] gs, input logic [7:0] bs,
                             input logic [7:0] rs);
        logic [7:0]           vals [5];
        logic [CFG_IDX_W-1:0] idx;
        int                   i;
        wait_idle();
        vals = '{dz, d1, gs, bs, rs};
        for (i = REG_DUTY_ZERO; i <= REG_RESET_SLOTS; i++) begin
            idx = CFG_IDX_W'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            sb.write_reg(idx, vals[i]);
            @(posedge clk);
        end
        idx = CFG_IDX_W'($urandom_range(REG_RESET_SLOTS + 1, (1 << CFG_IDX_W) - 1));
        vals[0] = pick_byte();
        cfg_index <= idx;
        cfg_data  <= vals[0];
        sb.write_reg(idx, vals[0]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one input word and hold it until the block takes it
    task automatic send_word(input logic cmd, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid   <= 1'b1;
        pixel_ch.command <= cmd;
        pixel_ch.red     <= r;
        pixel_ch.green   <= g;
        pixel_ch.blue    <= b;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        sb.note_word(cmd, r, g, b);
    endtask

    task automatic send_random_pixel();
        send_word(CMD_PIXEL, pick_byte(), pick_byte(), pick_byte());
    endtask

    task automatic send_random_eof();
        send_word(CMD_EOF, pick_byte(), pick_byte(), pick_byte());
    endtask

    // Slot receiver: random stalls, plus a long hold-off while words are offered
    initial begin
        int gap;
        slot_ch.ready <= 1'b0;
        slots_taken = 0;
        next_hold   = HOLD_EVERY;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (pixel_ch.valid && slots_taken >= next_hold) begin
                gap       = HOLD_CYCLES;
                next_hold = next_hold + HOLD_EVERY;
            end
            if (gap != 0) begin
                slot_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            slot_ch.ready <= 1'b1;
            @(posedge clk);
            while (!slot_ch.valid)
                @(posedge clk);
            sb.check_slot(slot_ch.duty, slot_ch.last);
            slots_taken++;
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long
    initial stall_cycles = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if ((pixel_ch.valid && pixel_ch.ready) || (slot_ch.valid && slot_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
                $display("ws2812_pixel_bit_encoder_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int n;
        sb = new();
        idle_on = 1'b0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_DUTY_ZERO;
        cfg_data         <= '0;
        pixel_ch.valid   <= 1'b0;
        pixel_ch.command <= CMD_PIXEL;
        pixel_ch.red     <= '0;
        pixel_ch.green   <= '0;
        pixel_ch.blue    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults, back to back: extremes and alternating bit patterns
        send_word(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
        send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_PIXEL, 8'hAA, 8'h55, 8'hAA);
        send_word(CMD_PIXEL, 8'h55, 8'hAA, 8'h55);
        send_word(CMD_PIXEL, 8'h80, 8'h80, 8'h80);
        send_word(CMD_EOF,   8'hFF, 8'hFF, 8'hFF);

        // Full-scale correction, extreme duties, single reset slot
        idle_on = 1'b1;
        load_regs(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'd1);
        send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_PIXEL, 8'h01, 8'h01, 8'h01);
        send_word(CMD_EOF,   8'h00, 8'h00, 8'h00);

        // Zero scales, inverted duties, longest reset
        load_regs(8'hFF, 8'h00, 8'h00, 8'h00, 8'd64);
        send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_EOF,   8'h5A, 8'hA5, 8'h3C);

        // Zero reset length: end of frame gives nothing but restarts the count
        load_regs(8'd19, 8'd38, 8'h80, 8'h01, 8'd0);
        send_word(CMD_PIXEL, 8'h0C, 8'hC8, 8'hFF);
        send_word(CMD_EOF,   8'hFF, 8'h00, 8'hFF);
        send_word(CMD_PIXEL, 8'hF0, 8'h0F, 8'h7F);
        send_word(CMD_EOF,   8'h00, 8'hFF, 8'h00);

        // Reset lengths above range clamp to the maximum; bit 7 is masked off
        load_regs(pick_byte(), pick_byte(), pick_byte(), pick_byte(), 8'd65);
        send_word(CMD_EOF, 8'h12, 8'h34, 8'h56);
        load_regs(pick_byte(), pick_byte(), pick_byte(), pick_byte(), 8'hFF);
        send_word(CMD_EOF, 8'h00, 8'h00, 8'h00);
        load_regs(pick_byte(), pick_byte(), pick_byte(), pick_byte(), 8'h80);
        send_word(CMD_EOF, 8'hFF, 8'hFF, 8'hFF);

        // Random phases: fresh registers, frames of random pixels
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_regs(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_slots());
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase == LONG_PHASE) begin
                // one frame past the pixel limit, so late pixels are dropped
                send_random_eof();
                for (n = 0; n < MAX_PIXELS_DEFAULT + 4; n++)
                    send_random_pixel();
                send_random_eof();
            end
            else begin
                for (n = 0; n < WORDS_PER_PHASE; n++) begin
                    if ($urandom_range(0, 7) == 0)
                        send_random_eof();
                    else
                        send_random_pixel();
                end
            end
        end

        // Drain and give stray slots a chance to show up
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ws2812_pixel_bit_encoder_tb: done, clean");
        else
            $display("ws2812_pixel_bit_encoder_tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/wpbe_pkg.sv
hw/rtl/wpbe_if.sv
hw/rtl/wpbe_cfg_regs.sv
hw/rtl/wpbe_color.sv
hw/rtl/wpbe_serializer.sv
hw/rtl/ws2812_pixel_bit_encoder.sv
dv/wpbe_tb_pkg.sv
dv/ws2812_pixel_bit_encoder_tb.sv
